>>> rtl/core/mshb_pkg.sv
// multi string hash bank: shared types, constants and arithmetic helpers
// no dependencies; used by the interfaces, the hash state module and the top level

package mshb_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned AccW  = 64;
	localparam int unsigned HashW = 63;
	localparam int unsigned SumW  = 16;
	localparam int unsigned HalfW = AccW / 2;

	localparam logic [AccW-1:0] RS_INIT = 64'd63689;
	localparam logic [AccW-1:0] RS_STEP = 64'd378551;
	localparam logic [AccW-1:0] JS_INIT = 64'd1315423911;

	typedef logic [ByteW-1:0] byte_t;
	typedef logic [AccW-1:0]  acc_t;
	typedef logic [HashW-1:0] hash_t;
	typedef logic [SumW-1:0]  csum_t;

	typedef struct packed {
		hash_t rs;
		hash_t js;
		hash_t pjw;
		hash_t elf;
		hash_t ap;
		csum_t ones_sum;
	} result_t;

	// low 64 bits of a 64 x 64 product, from three 32 x 32 partial products
	function automatic acc_t mul_lo(input acc_t a, input acc_t b);
		logic [AccW-1:0]  lo;
		logic [AccW-1:0]  cross_a;
		logic [AccW-1:0]  cross_b;
		logic [HalfW-1:0] cross_sum;
		lo        = a[HalfW-1:0] * b[HalfW-1:0];
		cross_a   = a[HalfW-1:0] * b[AccW-1:HalfW];
		cross_b   = a[AccW-1:HalfW] * b[HalfW-1:0];
		cross_sum = cross_a[HalfW-1:0] + cross_b[HalfW-1:0];
		return lo + {cross_sum, {HalfW{1'b0}}};
	endfunction

endpackage

>>> rtl/core/mshb_if.sv
// multi string hash bank: byte request and result request channels
// depends on mshb_pkg for the payload types

interface mshb_byte_if;
	logic                 valid;
	logic                 ready;
	mshb_pkg::byte_t      data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface mshb_result_if;
	logic                 valid;
	logic                 ready;
	mshb_pkg::hash_t      rs_value;
	mshb_pkg::hash_t      js_value;
	mshb_pkg::hash_t      pjw_value;
	mshb_pkg::hash_t      elf_value;
	mshb_pkg::hash_t      ap_value;
	mshb_pkg::csum_t      ones_sum_value;

	modport source (output valid, output rs_value, output js_value, output pjw_value,
		output elf_value, output ap_value, output ones_sum_value, input ready);
	modport sink   (input valid, input rs_value, input js_value, input pjw_value,
		input elf_value, input ap_value, input ones_sum_value, output ready);
endinterface

>>> rtl/core/mshb_hash_state.sv
// multi string hash bank: running hash accumulators and their per-byte update
// depends on mshb_pkg; the current result is presented combinationally

module mshb_hash_state (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  mshb_pkg::byte_t   data_byte,
	output mshb_pkg::result_t result
);

	mshb_pkg::acc_t  rs_q, rs_mult_q, js_q, pjw_q, elf_q, ap_q, sum_q;
	mshb_pkg::byte_t pend_q;
	logic            odd_q;

	mshb_pkg::acc_t  c64;
	mshb_pkg::acc_t  rs_d, rs_mult_d, js_d, pjw_d, elf_d, ap_d, sum_d;
	mshb_pkg::acc_t  pjw_h, elf_h;
	logic            terminator;

	logic [mshb_pkg::AccW-1:0]    sum_tail;
	logic [mshb_pkg::HalfW:0]     fold1;
	logic [mshb_pkg::HalfW+1:0]   fold2;

	assign c64        = {{(mshb_pkg::AccW-mshb_pkg::ByteW){1'b0}}, data_byte};
	assign terminator = (data_byte == '0);

	always_comb begin
		rs_d      = mshb_pkg::mul_lo(rs_q, rs_mult_q) + c64;
		rs_mult_d = mshb_pkg::mul_lo(rs_mult_q, mshb_pkg::RS_STEP);
		js_d      = js_q ^ ((js_q << 5) + c64 + (js_q >> 2));

		pjw_h = (pjw_q << 8) + c64;
		pjw_d = {8'h00, pjw_h[55:16], pjw_h[15:8] ^ pjw_h[63:56], pjw_h[7:0]};

		elf_h = (elf_q << 4) + c64;
		elf_d = {elf_h[63:32], 4'h0, elf_h[27:8], elf_h[7:4] ^ elf_h[31:28], elf_h[3:0]};

		if (odd_q) begin
			ap_d  = ap_q ^ ~((ap_q << 11) ^ c64 ^ (ap_q >> 5));
			sum_d = sum_q + {{(mshb_pkg::AccW-2*mshb_pkg::ByteW){1'b0}}, data_byte, pend_q};
		end else begin
			ap_d  = ap_q ^ ((ap_q << 7) ^ c64 ^ (ap_q >> 3));
			sum_d = sum_q;
		end
	end

	// checksum: odd tail byte, one 32-bit fold, then the 16-bit carry fold
	always_comb begin
		sum_tail = sum_q + (odd_q ? {{(mshb_pkg::AccW-mshb_pkg::ByteW){1'b0}}, pend_q} : '0);
		fold1    = {1'b0, sum_tail[mshb_pkg::AccW-1:mshb_pkg::HalfW]}
			+ {1'b0, sum_tail[mshb_pkg::HalfW-1:0]};
		fold2    = {1'b0, fold1} + {17'd0, fold1[mshb_pkg::HalfW:16]};
	end

	always_comb begin
		result.rs       = rs_q[mshb_pkg::HashW-1:0];
		result.js       = js_q[mshb_pkg::HashW-1:0];
		result.pjw      = pjw_q[mshb_pkg::HashW-1:0];
		result.elf      = elf_q[mshb_pkg::HashW-1:0];
		result.ap       = ap_q[mshb_pkg::HashW-1:0];
		result.ones_sum = ~fold2[mshb_pkg::SumW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q      <= '0;
			rs_mult_q <= mshb_pkg::RS_INIT;
			js_q      <= mshb_pkg::JS_INIT;
			pjw_q     <= '0;
			elf_q     <= '0;
			ap_q      <= '0;
			sum_q     <= '0;
			pend_q    <= '0;
			odd_q     <= 1'b0;
		end else if (take) begin
			if (terminator) begin
				rs_q      <= '0;
				rs_mult_q <= mshb_pkg::RS_INIT;
				js_q      <= mshb_pkg::JS_INIT;
				pjw_q     <= '0;
				elf_q     <= '0;
				ap_q      <= '0;
				sum_q     <= '0;
				pend_q    <= '0;
				odd_q     <= 1'b0;
			end else begin
				rs_q      <= rs_d;
				rs_mult_q <= rs_mult_d;
				js_q      <= js_d;
				pjw_q     <= pjw_d;
				elf_q     <= elf_d;
				ap_q      <= ap_d;
				sum_q     <= sum_d;
				if (!odd_q) begin
					pend_q <= data_byte;
				end
				odd_q     <= ~odd_q;
			end
		end
	end

endmodule

>>> rtl/core/multi_string_hash_bank_top.sv
// The block takes one string byte per cycle and keeps RS, JS, PJW, ELF, AP and a 16-bit
// ones' complement word checksum running side by side; a zero byte ends the string (an
// empty string is fine) and one result request follows, holding the five hashes cut to
// 63 bits and the checksum, after which every accumulator returns to its start value.
// A byte is taken in every cycle while the result register is empty or being drained;
// the result is valid in the cycle after its terminator is taken. The cycle is bounded by
// the RS multiply-accumulate, a 64-bit product built from three 32 x 32 partial products.
// depends on mshb_pkg, mshb_if and mshb_hash_state

module multi_string_hash_bank_top (
	input  logic                  clk,
	input  logic                  arst_n,
	mshb_byte_if.sink             bytes,
	mshb_result_if.source         hashes
);

	mshb_pkg::result_t cur_result;
	mshb_pkg::result_t res_q;
	logic              res_valid_q;
	logic              take;

	assign bytes.ready = !res_valid_q || hashes.ready;
	assign take        = bytes.valid && bytes.ready;

	mshb_hash_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (bytes.data_byte),
		.result    (cur_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && bytes.data_byte == '0) begin
			res_valid_q <= 1'b1;
		end else if (hashes.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && bytes.data_byte == '0) begin
			res_q <= cur_result;
		end
	end

	assign hashes.valid          = res_valid_q;
	assign hashes.rs_value       = res_q.rs;
	assign hashes.js_value       = res_q.js;
	assign hashes.pjw_value      = res_q.pjw;
	assign hashes.elf_value      = res_q.elf;
	assign hashes.ap_value       = res_q.ap;
	assign hashes.ones_sum_value = res_q.ones_sum;

endmodule

>>> sim/mshb_hash_checker.sv
// string hash checker: watches the byte and result channels, predicts each result request
// from the accepted bytes and compares every field; depends on mshb_pkg and mshb_if

module mshb_hash_checker
	import mshb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mshb_byte_if        byte_ch,
	mshb_result_if      result_ch,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam acc_t PJW_TOP_MASK   = 64'hFF00_0000_0000_0000;
	localparam acc_t ELF_NIBBLE     = 64'h0000_0000_F000_0000;
	localparam acc_t LOW_WORD_MASK  = 64'h0000_0000_FFFF_FFFF;

	typedef struct {
		acc_t  rs;
		acc_t  rs_mult;
		acc_t  js;
		acc_t  pjw;
		acc_t  elf;
		acc_t  ap;
		acc_t  word_total;
		byte_t held_low;
		bit    odd_pos;
	} string_state_t;

	string_state_t string_state;
	result_t       pending_digests[$];
	int unsigned   fault_tally = 0;
	int unsigned   due_count = 0;
	int unsigned   results_seen = 0;

	assign mismatches  = fault_tally;
	assign outstanding = due_count;

	function automatic string_state_t cleared_state();
		string_state_t s;
		s.rs         = '0;
		s.rs_mult    = RS_INIT;
		s.js         = JS_INIT;
		s.pjw        = '0;
		s.elf        = '0;
		s.ap         = '0;
		s.word_total = '0;
		s.held_low   = '0;
		s.odd_pos    = 1'b0;
		return s;
	endfunction

	function automatic string_state_t absorb_byte(input string_state_t s, input byte_t b);
		acc_t c;
		acc_t h;
		acc_t top;
		c         = {{(AccW-ByteW){1'b0}}, b};
		s.rs      = s.rs * s.rs_mult + c;
		s.rs_mult = s.rs_mult * RS_STEP;
		s.js      = s.js ^ ((s.js << 5) + c + (s.js >> 2));
		h   = (s.pjw << 8) + c;
		top = h & PJW_TOP_MASK;
		if (top != '0) begin
			h = (h ^ (top >> 48)) & ~PJW_TOP_MASK;
		end
		s.pjw = h;
		h   = (s.elf << 4) + c;
		top = h & ELF_NIBBLE;
		if (top != '0) begin
			h = h ^ (top >> 24);
			h = h & ~top;
		end
		s.elf = h;
		if (!s.odd_pos) begin
			s.ap       = s.ap ^ ((s.ap << 7) ^ c ^ (s.ap >> 3));
			s.held_low = b;
		end else begin
			s.ap         = s.ap ^ ~((s.ap << 11) ^ c ^ (s.ap >> 5));
			s.word_total = s.word_total + {{(AccW-2*ByteW){1'b0}}, b, s.held_low};
		end
		s.odd_pos = !s.odd_pos;
		return s;
	endfunction

	function automatic result_t digest_of(input string_state_t s);
		acc_t    t;
		result_t r;
		t = s.word_total;
		if (s.odd_pos) begin
			t = t + {{(AccW-ByteW){1'b0}}, s.held_low};
		end
		t = (t >> 32) + (t & LOW_WORD_MASK);
		t = t + (t >> 16);
		r.rs       = s.rs[HashW-1:0];
		r.js       = s.js[HashW-1:0];
		r.pjw      = s.pjw[HashW-1:0];
		r.elf      = s.elf[HashW-1:0];
		r.ap       = s.ap[HashW-1:0];
		r.ones_sum = ~t[SumW-1:0];
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("hash result %0d: %s", results_seen, msg);
		fault_tally++;
	endtask

	task automatic compare_field(input string field, input acc_t got, input acc_t want);
		if (got !== want) begin
			note_mismatch($sformatf("%s got %h want %h", field, got, want));
		end
	endtask

	task automatic check_result();
		result_t want;
		if (pending_digests.size() == 0) begin
			note_mismatch("result request with no terminated string");
		end else begin
			want = pending_digests.pop_front();
			compare_field("rs", acc_t'(result_ch.rs_value), acc_t'(want.rs));
			compare_field("js", acc_t'(result_ch.js_value), acc_t'(want.js));
			compare_field("pjw", acc_t'(result_ch.pjw_value), acc_t'(want.pjw));
			compare_field("elf", acc_t'(result_ch.elf_value), acc_t'(want.elf));
			compare_field("ap", acc_t'(result_ch.ap_value), acc_t'(want.ap));
			compare_field("ones_sum", acc_t'(result_ch.ones_sum_value), acc_t'(want.ones_sum));
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_state = cleared_state();
			pending_digests.delete();
			due_count = 0;
		end else begin
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				check_result();
			end
			if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
				if (byte_ch.data_byte == '0) begin
					pending_digests.push_back(digest_of(string_state));
					string_state = cleared_state();
				end else begin
					string_state = absorb_byte(string_state, byte_ch.data_byte);
				end
			end
			due_count = pending_digests.size();
		end
	end

endmodule

>>> sim/multi_string_hash_bank_top_tb.sv
// testbench top for the string hash bank: clock, reset, byte stimulus and result back-pressure
// depends on mshb_pkg, mshb_if, the block and mshb_hash_checker

module multi_string_hash_bank_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mshb_pkg::*;

	localparam int unsigned BYTE_TARGET      = 1050;
	localparam int unsigned SINK_HOLD_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT   = 2000;
	localparam int unsigned END_IDLE_CYCLES  = 8;

	localparam byte_t DIRECTED_BYTES [20] = '{
		8'h00,
		8'hFF, 8'h00,
		8'h01, 8'h00,
		8'h80, 8'h7F, 8'hAA, 8'h00,
		8'h55, 8'hAA, 8'hFF, 8'h01, 8'h00,
		8'h7F, 8'h80, 8'hFE, 8'h00,
		8'h00, 8'h00
	};

	logic        clk;
	logic        arst_n;
	logic        hold_sink;
	logic        calm_phase;
	int unsigned mismatch_count;
	int unsigned results_due;
	int unsigned bytes_offered;
	int unsigned quiet_cycles;

	mshb_byte_if   bytes_ch ();
	mshb_result_if hashes_ch ();

	multi_string_hash_bank_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_ch),
		.hashes (hashes_ch)
	);

	mshb_hash_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_ch     (bytes_ch),
		.result_ch   (hashes_ch),
		.mismatches  (mismatch_count),
		.outstanding (results_due)
	);

	initial clk = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic byte_t pick_char();
		case ($urandom_range(0, 7))
			0: begin
				return 8'hFF;
			end
			1: begin
				return 8'h01;
			end
			2: begin
				return 8'h80;
			end
			default: begin
				return byte_t'($urandom_range(1, 255));
			end
		endcase
	endfunction

	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 0;
		end else if (r < 80) begin
			return $urandom_range(1, 12);
		end else if (r < 97) begin
			return $urandom_range(13, 64);
		end
		return $urandom_range(200, 400);
	endfunction

	// called just after a falling edge, returns at the falling edge after acceptance
	task automatic offer(input byte_t b);
		bytes_ch.valid     <= 1'b1;
		bytes_ch.data_byte <= b;
		@(posedge clk);
		while (bytes_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		bytes_offered++;
		@(negedge clk);
	endtask

	task automatic maybe_gap();
		if (!calm_phase && $urandom_range(0, 7) == 0) begin
			bytes_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	task automatic send_string(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			maybe_gap();
			offer(pick_char());
		end
		maybe_gap();
		offer('0);
	endtask

	task automatic drain_pause();
		bytes_ch.valid <= 1'b0;
		wait (results_due == 0);
		@(negedge clk);
	endtask

	// result side back-pressure
	initial begin
		hashes_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				hashes_ch.ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				hold_sink = 1'b0;
			end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
				hashes_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				hashes_ch.ready <= 1'b1;
				if (!calm_phase) begin
					repeat ($urandom_range(0, 15)) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((bytes_ch.valid === 1'b1 && bytes_ch.ready === 1'b1) ||
			(hashes_ch.valid === 1'b1 && hashes_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		bit hold_done;
		bit pause_done;
		bytes_ch.valid     = 1'b0;
		bytes_ch.data_byte = '0;
		arst_n             = 1'b0;
		hold_sink          = 1'b0;
		calm_phase         = 1'b0;
		bytes_offered      = 0;
		quiet_cycles       = 0;
		hold_done          = 1'b0;
		pause_done         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes, empty, odd and even lengths
		foreach (DIRECTED_BYTES[i]) begin
			maybe_gap();
			offer(DIRECTED_BYTES[i]);
		end
		drain_pause();

		// one long string so the RS, JS and AP accumulators wrap
		send_string(300);

		while (bytes_offered < BYTE_TARGET) begin
			if (!hold_done && bytes_offered > 450) begin
				hold_done = 1'b1;
				hold_sink = 1'b1;
				repeat (12) send_string($urandom_range(0, 2));
			end else if (!pause_done && bytes_offered > 700) begin
				pause_done = 1'b1;
				drain_pause();
			end else begin
				if (bytes_offered > 900) begin
					calm_phase = 1'b1;
				end
				send_string(pick_length());
			end
		end

		bytes_ch.valid <= 1'b0;
		wait (results_due == 0);
		repeat (END_IDLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
